// File: hw/rtl/bexg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bexg_pkg
// Shared types, constants and the window arithmetic of the excess-green block.
// ----------------------------------------------------------------------------
package bexg_pkg;

    localparam int PIX_W   = 16;   // raw sample width
    localparam int EXG_W   = 8;    // result byte width
    localparam int WIDTH_W = 13;   // image_width register
    localparam int HEIGHT_W = 16;  // image_height register
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;

    localparam int EXG_SHIFT  = 10;
    localparam int EXG_OFFSET = 128;
    // p00 + p11 - p01 - p10 plus the bias fits this many bits, signed
    localparam int SUM_W = PIX_W + 3;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_IMAGE_WIDTH  = t_cfg_addr'(0);
    localparam t_cfg_addr CFG_IMAGE_HEIGHT = t_cfg_addr'(1);

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [EXG_W-1:0] t_exg;

    // signed 2x2 difference, sign flipped on odd x+y, floor shift and offset
    function automatic t_exg exg_calc(input t_pix p00, input t_pix p01,
                                      input t_pix p10, input t_pix p11,
                                      input logic odd);
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] biased;
        sum = $signed({3'b000, p00}) + $signed({3'b000, p11})
            - $signed({3'b000, p01}) - $signed({3'b000, p10});
        if (odd) begin
            sum = -sum;
        end
        biased = sum + SUM_W'(EXG_OFFSET << EXG_SHIFT);
        return biased[EXG_SHIFT +: EXG_W];
    endfunction

endpackage

// File: hw/rtl/bexg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bexg_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module bexg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // same-address read and write in one cycle returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bayer_excess_green_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_excess_green_index
// Excess-green index over 2x2 windows of a raw Bayer GR pixel stream.
// ----------------------------------------------------------------------------
// While the output accepts, it takes one raw pixel per clock and returns one
// byte per 2x2 window when its bottom-right pixel arrives; pixels of the
// first column and row give no result. The previous row lives in a line
// buffer of MAX_WIDTH words that is read and written once per pixel at the
// column address, in the same cycle, so the block keeps that rate. A result
// passes the read stage, then the output register; a stalled output holds
// one result while one more pixel waits in the read stage. The line buffer
// is not cleared after reset; every frame's first row fills it before use.
module bayer_excess_green_index #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  bexg_pkg::t_cfg_addr                i_cfg_addr,
    input  logic [bexg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // pixel stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // raw_pixel
    input  logic                               s_axis_tuser,  // frame_start
    // result stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // exg_value
    output logic                               m_axis_tlast   // frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH);       // column / address bits
    localparam int WCW  = $clog2(MAX_WIDTH + 1);   // holds the width itself
    localparam int CMPW = (WCW > bexg_pkg::WIDTH_W) ? WCW : bexg_pkg::WIDTH_W;
    localparam int RW   = bexg_pkg::HEIGHT_W;

    // configuration
    logic [bexg_pkg::WIDTH_W-1:0]  r_img_width;
    logic [bexg_pkg::HEIGHT_W-1:0] r_img_height;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // read stage
    logic           r_s1_valid;
    bexg_pkg::t_pix r_s1_pix;
    logic           r_s1_prod;
    logic           r_s1_odd;
    logic           r_s1_fend;

    // pixels left of the window, current and previous row
    bexg_pkg::t_pix r_left_cur;
    bexg_pkg::t_pix r_left_prev;

    // output register
    logic           r_out_valid;
    bexg_pkg::t_exg r_out_exg;
    logic           r_out_fend;

    logic [CMPW-1:0] w_ext;
    logic [WCW-1:0]  w_eff;
    logic [RW-1:0]   h_eff;
    logic [CW-1:0]   cur_col;
    logic [RW:0]     row_inc;
    logic [RW-1:0]   cur_row;
    logic [WCW-1:0]  col_plus;
    logic [RW:0]     row_plus;
    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic            in_acc;
    logic            s1_adv;
    bexg_pkg::t_pix  above;

    // effective frame size
    always_comb begin
        w_ext = CMPW'(r_img_width);
        if (w_ext < CMPW'(2)) begin
            w_ext = CMPW'(2);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_ext = CMPW'(MAX_WIDTH);
        end
        w_eff = WCW'(w_ext);
        h_eff = (r_img_height < RW'(2)) ? RW'(2) : r_img_height;
    end

    // position of the incoming pixel, then the position after it
    always_comb begin
        cur_col = s_axis_tuser ? '0 : r_col;
        row_inc = {1'b0, (s_axis_tuser ? '0 : r_row)};
        if (WCW'(cur_col) >= w_eff) begin
            cur_col = '0;
            row_inc = row_inc + 1'b1;
        end
        cur_row = (row_inc >= {1'b0, h_eff}) ? '0 : RW'(row_inc);

        col_plus = WCW'(cur_col) + 1'b1;
        row_plus = {1'b0, cur_row};
        n_col    = CW'(col_plus);
        n_row    = cur_row;
        if (col_plus >= w_eff) begin
            n_col    = '0;
            row_plus = row_plus + 1'b1;
            n_row    = (row_plus >= {1'b0, h_eff}) ? '0 : RW'(row_plus);
        end
    end

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    bexg_ram #(
        .WIDTH (bexg_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (cur_col),
        .i_wdata (s_axis_tdata),
        .i_re    (in_acc),
        .i_raddr (cur_col),
        .o_rdata (above)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= bexg_pkg::WIDTH_W'(640);
            r_img_height <= bexg_pkg::HEIGHT_W'(480);
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
            r_left_cur   <= '0;
            r_left_prev  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bexg_pkg::CFG_IMAGE_WIDTH: begin
                        r_img_width <= i_cfg_wdata[bexg_pkg::WIDTH_W-1:0];
                    end
                    bexg_pkg::CFG_IMAGE_HEIGHT: begin
                        r_img_height <= i_cfg_wdata[bexg_pkg::HEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end

            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end

            if (r_s1_valid && s1_adv) begin
                r_left_cur  <= r_s1_pix;
                r_left_prev <= above;
            end

            if (s1_adv) begin
                r_out_valid <= r_s1_valid && r_s1_prod;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= s_axis_tdata;
            r_s1_prod <= (cur_col != '0) && (cur_row != '0);
            // parity of (x-1)+(y-1) equals parity of col+row
            r_s1_odd  <= cur_col[0] ^ cur_row[0];
            r_s1_fend <= (WCW'(cur_col) == w_eff - 1'b1) && (cur_row == h_eff - 1'b1);
        end
        if (r_s1_valid && s1_adv) begin
            r_out_exg  <= bexg_pkg::exg_calc(r_left_prev, above, r_left_cur,
                                             r_s1_pix, r_s1_odd);
            r_out_fend <= r_s1_fend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_exg;
    assign m_axis_tlast  = r_out_fend;

endmodule

// File: hw/rtl/bexg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bexg_checker
// Port-level checks of the excess-green block, bound to the top level.
// ----------------------------------------------------------------------------
module bexg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [bexg_pkg::EXG_W-1:0]  m_axis_tdata,
    input logic                        m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a free output side never blocks the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked with output side ready");

    // input only backs up behind a pending result
    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without a stalled result");

endmodule

bind bayer_excess_green_index bexg_checker u_bexg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/bexg_window_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bexg_window_monitor
// Watches the size-register port, the pixel stream and the result stream of
// the excess-green block, predicts every result beat from the accepted pixel
// beats and compares each one in order against what the block delivers.
// ----------------------------------------------------------------------------
module bexg_window_monitor #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  bexg_pkg::t_cfg_addr              i_cfg_addr,
    input  logic [bexg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_pix_valid,
    input  logic                             i_pix_ready,
    input  bexg_pkg::t_pix                   i_pix,
    input  logic                             i_frame_start,
    input  logic                             i_exg_valid,
    input  logic                             i_exg_ready,
    input  bexg_pkg::t_exg                   i_exg,
    input  logic                             i_frame_end,
    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_results
);

    typedef struct packed {
        bexg_pkg::t_exg value;
        logic           frame_end;
    } t_exg_beat;

    logic [bexg_pkg::WIDTH_W-1:0]  width_reg;
    logic [bexg_pkg::HEIGHT_W-1:0] height_reg;
    bexg_pkg::t_pix                prev_row [MAX_WIDTH];
    bexg_pkg::t_pix                left_cur;
    bexg_pkg::t_pix                left_above;
    int unsigned                   col_pos;
    int unsigned                   row_pos;
    t_exg_beat                     expected_exg [$];
    int                            mismatch_count;
    int                            result_count;

    initial begin
        o_mismatches = 0;
        o_pending = 0;
        o_results = 0;
    end

    task automatic predict_window(input bexg_pkg::t_pix pix, input logic frame_start);
        int unsigned    w;
        int unsigned    h;
        int unsigned    col;
        int unsigned    row;
        bexg_pkg::t_pix above;
        int             diff;
        t_exg_beat      beat;
        w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg < 2) ? 2 : height_reg;
        if (frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        // a size shrunk under the current position wraps before the pixel is taken
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) begin
            row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        above = prev_row[col];
        if (col >= 1 && row >= 1) begin
            diff = int'(left_above) + int'(pix) - int'(above) - int'(left_cur);
            // window corner is (col-1,row-1), same parity as col+row
            if ((col + row) % 2 == 1) begin
                diff = -diff;
            end
            diff = diff + (bexg_pkg::EXG_OFFSET << bexg_pkg::EXG_SHIFT);
            beat.value = bexg_pkg::t_exg'(diff >>> bexg_pkg::EXG_SHIFT);
            beat.frame_end = (col == w - 1) && (row == h - 1);
            expected_exg.push_back(beat);
        end
        prev_row[col] = pix;
        left_above = above;
        left_cur = pix;
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) begin
                row = 0;
            end
        end
        col_pos = col;
        row_pos = row;
    endtask

    always @(posedge i_clk) begin : watch
        t_exg_beat want;
        if (!i_rst_n) begin
            width_reg = bexg_pkg::WIDTH_W'(640);
            height_reg = bexg_pkg::HEIGHT_W'(480);
            foreach (prev_row[i]) begin
                prev_row[i] = '0;
            end
            left_cur = '0;
            left_above = '0;
            col_pos = 0;
            row_pos = 0;
            expected_exg.delete();
            mismatch_count = 0;
            result_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bexg_pkg::CFG_IMAGE_WIDTH:
                        width_reg = i_cfg_wdata[bexg_pkg::WIDTH_W-1:0];
                    bexg_pkg::CFG_IMAGE_HEIGHT:
                        height_reg = i_cfg_wdata[bexg_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            // an output beat always belongs to an earlier pixel, so compare first
            if (i_exg_valid && i_exg_ready) begin
                result_count++;
                if (expected_exg.size() == 0) begin
                    $display("%0t: unexpected result beat: value %0d last %0b", $time,
                             i_exg, i_frame_end);
                    mismatch_count++;
                end else begin
                    want = expected_exg.pop_front();
                    if (want.value !== i_exg || want.frame_end !== i_frame_end) begin
                        $display({"%0t: result mismatch: expected value %0d last %0b,",
                                  " got value %0d last %0b"},
                                 $time, want.value, want.frame_end, i_exg, i_frame_end);
                        mismatch_count++;
                    end
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                predict_window(i_pix, i_frame_start);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending <= expected_exg.size();
        o_results <= result_count;
    end

endmodule

// File: bench/bayer_excess_green_index_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_excess_green_index_tb
// Stimulus and verdict for the excess-green block. Drives a short directed run
// of extreme 2x2 windows, then random Bayer frames over many image sizes with
// bursty input and a stalling output; a side monitor predicts and compares.
// ----------------------------------------------------------------------------
module bayer_excess_green_index_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int MAX_W        = 4096;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_EVERY_THIRD
    } t_sink_mode;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    bexg_pkg::t_cfg_addr             i_cfg_addr;
    logic [bexg_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata;  // raw_pixel
    logic                            s_axis_tuser;  // frame_start
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [7:0]                      m_axis_tdata;  // exg_value
    logic                            m_axis_tlast;  // frame_end

    int          mismatches;
    int          pending;
    int          results;
    logic        long_hold_req;
    int unsigned burst_left;
    int unsigned pixels_sent;
    int unsigned settings_used;
    int unsigned eff_width;
    int unsigned frame_pos;
    int unsigned frame_len;
    logic        restart_due;

    bayer_excess_green_index #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bexg_window_monitor #(
        .MAX_WIDTH(MAX_W)
    ) window_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_pix_valid   (s_axis_tvalid),
        .i_pix_ready   (s_axis_tready),
        .i_pix         (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_exg_valid   (m_axis_tvalid),
        .i_exg_ready   (m_axis_tready),
        .i_exg         (m_axis_tdata),
        .i_frame_end   (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic bexg_pkg::t_pix random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return bexg_pkg::t_pix'($urandom_range(0, 65535));
        endcase
    endfunction

    // all tasks below are entered right after a rising edge
    task automatic send_pixel(input bexg_pkg::t_pix pix, input logic frame_start);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= frame_start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // pixels that make no result may still be in the pipe
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [bexg_pkg::CFG_DATA_W-1:0] w_val,
                            input logic [bexg_pkg::CFG_DATA_W-1:0] h_val);
        int unsigned new_w;
        int unsigned new_h;
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= bexg_pkg::CFG_IMAGE_WIDTH;
        i_cfg_wdata <= w_val;
        @(posedge i_clk);
        i_cfg_addr <= bexg_pkg::CFG_IMAGE_HEIGHT;
        i_cfg_wdata <= h_val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        new_w = w_val[bexg_pkg::WIDTH_W-1:0];
        new_w = (new_w < 2) ? 2 : ((new_w > MAX_W) ? MAX_W : new_w);
        new_h = h_val[bexg_pkg::HEIGHT_W-1:0];
        new_h = (new_h < 2) ? 2 : new_h;
        // a wider row must be refilled from row 0 before the line store is read
        restart_due = (new_w > eff_width);
        if (restart_due) begin
            frame_pos = 0;
        end
        eff_width = new_w;
        frame_len = new_w * new_h;
        settings_used++;
    endtask

    // random pixels in frame order; noise puts a start flag mid-frame
    task automatic random_pixels(input int unsigned count, input int unsigned noise_odds);
        logic frame_start;
        repeat (count) begin
            frame_start = restart_due || (frame_pos == 0 && $urandom_range(0, 1) == 1)
                       || (noise_odds != 0 && $urandom_range(1, noise_odds) == 1);
            restart_due = 1'b0;
            if (frame_start) begin
                frame_pos = 0;
            end
            send_pixel(random_pixel(), frame_start);
            frame_pos = (frame_pos + 1) % frame_len;
        end
    endtask

    initial begin : result_sink
        int unsigned stretch_left;
        int unsigned hold_left;
        t_sink_mode  sink_mode;
        logic        hold_taken;
        m_axis_tready <= 1'b0;
        stretch_left = 0;
        hold_left = 0;
        sink_mode = SINK_OPEN;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (stretch_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                stretch_left = $urandom_range(32, 256);
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_OPEN: m_axis_tready <= 1'b1;
                    SINK_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= (stretch_left % 3 == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        bexg_pkg::t_pix dir_2x2 [8];
        bexg_pkg::t_pix dir_3x3 [16];
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= bexg_pkg::CFG_IMAGE_WIDTH;
        i_cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        long_hold_req <= 1'b0;
        burst_left = 0;
        pixels_sent = 0;
        settings_used = 0;
        eff_width = 0;
        frame_pos = 0;
        frame_len = 4;
        restart_due = 1'b0;
        // strongest positive then strongest negative window
        dir_2x2 = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                    16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
        // checkerboard gives full-scale windows of both parities
        dir_3x3 = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                    16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF,
                    16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // second 2x2 frame follows with no start flag
        set_size(2, 2);
        foreach (dir_2x2[i]) begin
            send_pixel(dir_2x2[i], i == 0);
        end
        // frame, part of the next one, then a restart in the middle of a row
        set_size(3, 3);
        foreach (dir_3x3[i]) begin
            send_pixel(dir_3x3[i], i == 0 || i == 13);
        end

        // out-of-range sizes act as the nearest legal ones
        set_size(0, 1);
        random_pixels(60, 80);
        set_size(1, 0);
        random_pixels(60, 80);
        set_size(2, 16'hFFFF);
        random_pixels(120, 80);
        // widest row only partly filled, then shrunk under the current position
        set_size(MAX_W, 3);
        random_pixels(40, 0);
        set_size(5, 4);
        random_pixels(100, 80);
        // block fills up while the output is held off
        set_size(6, 3);
        long_hold_req <= 1'b1;
        random_pixels(150, 80);
        long_hold_req <= 1'b0;
        repeat (6) begin
            set_size(bexg_pkg::CFG_DATA_W'($urandom_range(2, 20)),
                     bexg_pkg::CFG_DATA_W'($urandom_range(2, 6)));
            random_pixels($urandom_range(50, 130), 80);
        end
        // clamped wide row partly filled, then top bits beyond the register dropped
        set_size(16'hFFFF, 2);
        random_pixels(64, 0);
        set_size(16'hE003, 3);
        random_pixels(60, 80);
        set_size(3, 2);
        random_pixels(80, 80);

        wait_drained();
        $display("sent %0d pixel beats and checked %0d excess-green results", pixels_sent,
                 results);
        $display("over %0d image sizes, clamped ones included, with a long output stall",
                 settings_used);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bexg_pkg.sv
hw/rtl/bexg_ram.sv
hw/rtl/bayer_excess_green_index.sv
hw/rtl/bexg_checker.sv
bench/bexg_window_monitor.sv
bench/bayer_excess_green_index_tb.sv
